// ===== rtl/fpdf_pkg.sv =====
`timescale 1ns / 1ps

package fpdf_pkg;

	// input value width and the decimal digits its magnitude can reach
	localparam int MAG_W      = 35;
	localparam int MAG_DIGITS = 11;

	localparam int CFG_W     = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_INTEGER_DIGITS  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRACTION_DIGITS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHOW_SIGN       = 2'd2;

	localparam logic [CFG_W-1:0] RST_INTEGER_DIGITS  = 4'd4;
	localparam logic [CFG_W-1:0] RST_FRACTION_DIGITS = 4'd0;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;

	localparam logic [3:0] BCD_NINE = 4'd9;
	localparam logic [3:0] BCD_FIVE = 4'd5;
	localparam logic [3:0] BCD_ADJ  = 4'd3;

	typedef struct packed {
		logic [CFG_W-1:0] integer_digits;
		logic [CFG_W-1:0] fraction_digits;
		logic             show_sign;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic neg;
	} conv_stat_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_SIGN,
		EM_DIGIT,
		EM_POINT
	} emit_state_t;

endpackage

// ===== rtl/fixed_point_decimal_text_formatter_top.sv =====
`timescale 1ns / 1ps

// Fixed-point decimal text formatter.
// Input channel (in_valid/in_ready, scaled_value): one signed value per transaction,
// already multiplied by ten to the power of the fraction digit count.
// Output channel (out_valid/out_ready, character, last): one ASCII character per
// transaction, an optional sign, the integer positions with leading blanks, an
// optional point and the fraction digits; last marks the final character.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 integer digits,
// 1 fraction digits, 2 sign display); write only while no value is in flight.
// The magnitude passes msb first, bit by bit, through a row of BCD digit cells; a new
// value is taken only once the row is idle and its digits have been handed on. The
// character stage sends up to MAX_DIGITS + 2 characters per value, overlapped with the
// conversion of the next value.
// Reset gives 4 integer digits, no fraction digits, no sign, and empties all stages.
// When the receiver stalls the character register holds; the character stage and
// then the cell row fill, after which in_ready stays low.

module fixed_point_decimal_text_formatter_top #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpdf_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [fpdf_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [fpdf_pkg::MAG_W-1:0]   scaled_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          character,
	output logic                                last
);
	import fpdf_pkg::*;

	localparam int NCELL = (MAX_DIGITS > MAG_DIGITS) ? MAX_DIGITS : MAG_DIGITS;

	cfg_t                  cfg_q;
	conv_stat_t            conv_stat;
	logic [NCELL-1:0][3:0] conv_digits;
	logic                  take;
	logic                  start;
	logic                  in_neg;
	logic [MAG_W-1:0]      in_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.integer_digits  <= RST_INTEGER_DIGITS;
			cfg_q.fraction_digits <= RST_FRACTION_DIGITS;
			cfg_q.show_sign       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTEGER_DIGITS:  cfg_q.integer_digits  <= cfg_data;
				REG_FRACTION_DIGITS: cfg_q.fraction_digits <= cfg_data;
				REG_SHOW_SIGN:       cfg_q.show_sign       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_neg   = scaled_value[MAG_W-1];
	assign in_mag   = in_neg ? (~$unsigned(scaled_value)) + MAG_W'(1) : $unsigned(scaled_value);
	assign in_ready = !conv_stat.busy && (!conv_stat.done || take);
	assign start    = in_valid && in_ready;

	fpdf_conv #(
		.NCELL (NCELL)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_mag (in_mag),
		.start_neg (in_neg),
		.take      (take),
		.stat      (conv_stat),
		.digits    (conv_digits)
	);

	fpdf_emit #(
		.MAX_DIGITS (MAX_DIGITS),
		.NCELL      (NCELL)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.conv_stat   (conv_stat),
		.conv_digits (conv_digits),
		.take        (take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.character   (character),
		.last        (last)
	);

	a_take_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> conv_stat.done)
		else $error("digits taken before conversion finished");

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (conv_stat.busy && !in_ready))
		else $error("accepted value did not start conversion");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (character >= CH_ZERO && character <= CH_NINE))
		else $error("final character is not a digit");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == CH_SPACE || character == CH_PLUS ||
			character == CH_MINUS || character == CH_POINT ||
			(character >= CH_ZERO && character <= CH_NINE)))
		else $error("illegal output character");

endmodule

// ===== rtl/fpdf_bcd_cell.sv =====
`timescale 1ns / 1ps

module fpdf_bcd_cell (
	input  logic       clk,
	input  logic       clear,
	input  logic       shift,
	input  logic       cin,
	output logic       cout,
	output logic [3:0] digit
);
	import fpdf_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add three before the shift so the digit carries at ten
	assign adj   = (digit_q >= BCD_FIVE) ? digit_q + BCD_ADJ : digit_q;
	assign cout  = adj[3];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (clear) begin
			digit_q <= '0;
		end else if (shift) begin
			digit_q <= {adj[2:0], cin};
		end
	end

endmodule

// ===== rtl/fpdf_conv.sv =====
`timescale 1ns / 1ps

module fpdf_conv #(
	parameter int NCELL = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [fpdf_pkg::MAG_W-1:0]       start_mag,
	input  logic                             start_neg,
	input  logic                             take,
	output fpdf_pkg::conv_stat_t             stat,
	output logic [NCELL-1:0][3:0]            digits
);
	import fpdf_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] mag_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [NCELL:0]   chain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (take) begin
				done_q <= 1'b0;
			end
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= start_mag;
			neg_q <= start_neg;
		end else if (busy_q) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
		end
	end

	// magnitude enters msb first at the least significant digit
	assign chain[0] = mag_q[MAG_W-1];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fpdf_bcd_cell u_cell (
			.clk   (clk),
			.clear (start),
			.shift (busy_q),
			.cin   (chain[i]),
			.cout  (chain[i+1]),
			.digit (digits[i])
		);
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.neg  = neg_q;

endmodule

// ===== rtl/fpdf_emit.sv =====
`timescale 1ns / 1ps

module fpdf_emit #(
	parameter int MAX_DIGITS = 10,
	parameter int NCELL      = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpdf_pkg::cfg_t        cfg,
	input  fpdf_pkg::conv_stat_t  conv_stat,
	input  logic [NCELL-1:0][3:0] conv_digits,
	output logic                  take,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            character,
	output logic                  last
);
	import fpdf_pkg::*;

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int XW = (CW > CFG_W) ? CW : CFG_W;
	localparam int IW = $clog2(NCELL);

	emit_state_t           state_q, state_d;
	logic [NCELL-1:0][3:0] dig_q;
	logic [XW-1:0]         idx_q;
	logic                  sat_q;
	logic                  neg_q;
	logic                  shown_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [XW-1:0] ni_c, lim, nf_c, total;
	logic          sat_in;
	logic          adv;
	logic          emit;
	logic [7:0]    ch;
	logic          lst;
	logic [3:0]    d;
	logic          shown_now;

	// clip the digit counts to the available positions
	always_comb begin
		if (cfg.integer_digits == '0) begin
			ni_c = XW'(1);
		end else if (XW'(cfg.integer_digits) > XW'(MAX_DIGITS)) begin
			ni_c = XW'(MAX_DIGITS);
		end else begin
			ni_c = XW'(cfg.integer_digits);
		end
		lim = XW'(MAX_DIGITS) - ni_c;
		if (XW'(cfg.fraction_digits) > lim) begin
			nf_c = lim;
		end else begin
			nf_c = XW'(cfg.fraction_digits);
		end
		total = ni_c + nf_c;
	end

	// any digit beyond the shown positions means the value overflows
	always_comb begin
		sat_in = 1'b0;
		for (int k = 0; k < NCELL; k++) begin
			if (XW'(k) >= total && conv_digits[k] != '0) begin
				sat_in = 1'b1;
			end
		end
	end

	assign adv       = !out_valid_q || out_ready;
	assign d         = sat_q ? BCD_NINE : dig_q[idx_q[IW-1:0]];
	// the last integer digit and everything after it always show
	assign shown_now = shown_q || (d != '0) || (idx_q <= nf_c);

	always_comb begin
		state_d = state_q;
		take    = 1'b0;
		emit    = 1'b0;
		ch      = CH_SPACE;
		lst     = 1'b0;
		case (state_q)
			EM_IDLE: begin
				if (conv_stat.done) begin
					take    = 1'b1;
					state_d = cfg.show_sign ? EM_SIGN : EM_DIGIT;
				end
			end
			EM_SIGN: begin
				if (adv) begin
					emit    = 1'b1;
					ch      = neg_q ? CH_MINUS : CH_PLUS;
					state_d = EM_DIGIT;
				end
			end
			EM_POINT: begin
				if (adv) begin
					emit    = 1'b1;
					ch      = CH_POINT;
					state_d = EM_DIGIT;
				end
			end
			EM_DIGIT: begin
				if (adv) begin
					emit = 1'b1;
					ch   = shown_now ? CH_ZERO + {4'b0000, d} : CH_SPACE;
					if (idx_q == '0) begin
						lst = 1'b1;
						if (conv_stat.done) begin
							take    = 1'b1;
							state_d = cfg.show_sign ? EM_SIGN : EM_DIGIT;
						end else begin
							state_d = EM_IDLE;
						end
					end else if (nf_c != '0 && idx_q == nf_c) begin
						state_d = EM_POINT;
					end else begin
						state_d = EM_DIGIT;
					end
				end
			end
			default: begin
				state_d = EM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dig_q   <= conv_digits;
			sat_q   <= sat_in;
			neg_q   <= conv_stat.neg;
			idx_q   <= total - XW'(1);
			shown_q <= 1'b0;
		end else if (emit && state_q == EM_DIGIT) begin
			idx_q   <= idx_q - XW'(1);
			shown_q <= shown_now;
		end
		if (emit) begin
			char_q <= ch;
			last_q <= lst;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

// ===== sim/tb_fixed_point_decimal_text_formatter_top.sv =====
`timescale 1ns / 1ps

module tb_fixed_point_decimal_text_formatter_top;
	import fpdf_pkg::*;

	localparam int MAX_DIGITS = 10;
	localparam int MAX_GAP    = 17;
	localparam int LONG_STALL = 500;
	localparam int SETTLE     = 48;
	localparam int LIMIT      = 400000;
	localparam int PHASE_ITEMS = 27;

	// index with no register behind it, writes to it are ignored
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [MAG_W-1:0] MOST_NEG = {1'b1, {(MAG_W-1){1'b0}}};
	localparam logic signed [MAG_W-1:0] MOST_POS = {1'b0, {(MAG_W-1){1'b1}}};

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} text_char_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]    cfg_index = REG_INTEGER_DIGITS;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [MAG_W-1:0] scaled_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [7:0]              character;
	logic                    last;

	// format registers as the block should hold them
	logic [CFG_W-1:0] fmt_int_digits = RST_INTEGER_DIGITS;
	logic [CFG_W-1:0] fmt_frac_digits = RST_FRACTION_DIGITS;
	logic             fmt_show_sign = 1'b0;

	logic signed [MAG_W-1:0] pending_values[$];
	text_char_t              expected_text[$];

	logic no_idle = 1'b0;
	logic long_stall_req = 1'b0;
	logic stall_seen = 1'b0;
	int   tx_gap = 0;
	int   rx_wait = 0;
	int   mismatches = 0;
	int   cycle_count = 0;

	fixed_point_decimal_text_formatter_top #(
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.scaled_value(scaled_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last(last)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] ten_to(input int k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++)
			p = p * 64'd10;
		return p;
	endfunction

	// expands one value into the characters it should produce
	function automatic void format_value(input logic signed [MAG_W-1:0] v);
		logic [MAG_W-1:0] raw;
		logic [63:0]      mag;
		logic [63:0]      limit;
		logic [63:0]      div;
		logic [63:0]      d;
		logic             neg;
		logic             shown;
		int               ni;
		int               nf;
		int               total;
		text_char_t       tc;
		raw = v;
		neg = raw[MAG_W-1];
		mag = neg ? ((64'd1 << MAG_W) - 64'(raw)) : 64'(raw);
		ni = int'(fmt_int_digits);
		if (ni < 1)
			ni = 1;
		if (ni > MAX_DIGITS)
			ni = MAX_DIGITS;
		nf = int'(fmt_frac_digits);
		if (nf > MAX_DIGITS - ni)
			nf = MAX_DIGITS - ni;
		total = ni + nf;
		limit = ten_to(total) - 64'd1;
		if (mag > limit)
			mag = limit;
		if (fmt_show_sign) begin
			tc.ch = neg ? CH_MINUS : CH_PLUS;
			tc.lst = 1'b0;
			expected_text.push_back(tc);
		end
		shown = 1'b0;
		for (int n = 0; n < total; n++) begin
			div = ten_to(total - 1 - n);
			d = mag / div;
			mag = mag - d * div;
			if (n == ni && nf != 0) begin
				tc.ch = CH_POINT;
				tc.lst = 1'b0;
				expected_text.push_back(tc);
			end
			if (d != 0 || n + 1 >= ni)
				shown = 1'b1;
			tc.ch = shown ? (CH_ZERO + d[7:0]) : CH_SPACE;
			tc.lst = (n == total - 1);
			expected_text.push_back(tc);
		end
	endfunction

	function automatic logic [MAG_W-1:0] random_value();
		logic [63:0] r;
		logic [63:0] m;
		r = {$urandom(), $urandom()};
		m = ten_to($urandom_range(0, 11));
		case ($urandom_range(0, 3))
			0: begin
				return r[MAG_W-1:0];
			end
			1: begin
				m = r % m;
			end
			2: begin
				// around a digit-count boundary
				m = m - 64'd2 + 64'($urandom_range(0, 2));
			end
			default: begin
				m = 64'($urandom_range(0, 20));
			end
		endcase
		return r[63] ? -m[MAG_W-1:0] : m[MAG_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic wait_drained();
		while (pending_values.size() != 0 || in_valid || expected_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_format(input logic [CFG_W-1:0] int_d, input logic [CFG_W-1:0] frac_d,
			input logic [CFG_W-1:0] sign_data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_INTEGER_DIGITS;
		cfg_data <= int_d;
		@(posedge clk);
		cfg_index <= REG_FRACTION_DIGITS;
		cfg_data <= frac_d;
		@(posedge clk);
		cfg_index <= REG_SHOW_SIGN;
		cfg_data <= sign_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		fmt_int_digits = int_d;
		fmt_frac_digits = frac_d;
		fmt_show_sign = sign_data[0];
	endtask

	// sender: presents queued values, predicts the text of each accepted one
	always @(posedge clk or negedge arst_n) begin
		logic                    nxt_valid;
		int                      nxt_gap;
		logic signed [MAG_W-1:0] nxt_value;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			nxt_valid = in_valid;
			nxt_gap = tx_gap;
			nxt_value = scaled_value;
			if (in_valid && in_ready) begin
				format_value(scaled_value);
				nxt_valid = 1'b0;
				nxt_gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (!nxt_valid) begin
				if (nxt_gap > 0)
					nxt_gap--;
				else if (pending_values.size() != 0) begin
					nxt_value = pending_values.pop_front();
					nxt_valid = 1'b1;
				end
			end
			in_valid <= nxt_valid;
			tx_gap <= nxt_gap;
			scaled_value <= nxt_value;
		end
	end

	// receiver: random back-pressure and the character check
	always @(posedge clk or negedge arst_n) begin
		logic       nxt_ready;
		int         nxt_wait;
		text_char_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
			stall_seen <= 1'b0;
		end else begin
			nxt_ready = out_ready;
			nxt_wait = rx_wait;
			if (out_valid && out_ready) begin
				if (expected_text.size() == 0)
					report_mismatch($sformatf("unexpected character 0x%02h last %0b",
						character, last));
				else begin
					want = expected_text.pop_front();
					if (character !== want.ch)
						report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
							character, want.ch));
					if (last !== want.lst)
						report_mismatch($sformatf("last %0b, wanted %0b on 0x%02h",
							last, want.lst, want.ch));
				end
				nxt_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
				nxt_ready = (nxt_wait == 0);
			end else if (!out_ready) begin
				if (nxt_wait > 1)
					nxt_wait--;
				else begin
					nxt_wait = 0;
					nxt_ready = 1'b1;
				end
			end
			if (long_stall_req != stall_seen) begin
				nxt_wait = LONG_STALL;
				nxt_ready = 1'b0;
			end
			stall_seen <= long_stall_req;
			out_ready <= nxt_ready;
			rx_wait <= nxt_wait;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] int_d;
		logic [CFG_W-1:0] frac_d;
		logic [CFG_W-1:0] sign_data;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset format: four integer places, no point, no sign
		pending_values.push_back(35'sd0);
		pending_values.push_back(35'sd1);
		pending_values.push_back(-35'sd1);
		pending_values.push_back(35'sd9999);
		pending_values.push_back(35'sd10000);
		pending_values.push_back(-35'sd10000);
		pending_values.push_back(MOST_POS);
		pending_values.push_back(MOST_NEG);
		pending_values.push_back(35'sd9999999999);
		pending_values.push_back(-35'sd9999999999);
		pending_values.push_back(35'sd305);
		pending_values.push_back(-35'sd7);
		wait_drained();

		// widest integer part with sign, zero gives a plus
		set_format(4'd10, 4'd0, 4'd1);
		pending_values.push_back(35'sd0);
		pending_values.push_back(-35'sd1);
		pending_values.push_back(35'sd9999999999);
		pending_values.push_back(MOST_NEG);
		pending_values.push_back(35'sd1234567890);
		wait_drained();

		// zero integer places and an oversized fraction, both clipped
		set_format(4'd0, 4'd15, 4'd1);
		pending_values.push_back(35'sd0);
		pending_values.push_back(-35'sd5);
		pending_values.push_back(35'sd123456789);
		pending_values.push_back(MOST_POS);
		wait_drained();

		// integer places above the maximum
		set_format(4'd15, 4'd3, 4'd0);
		pending_values.push_back(35'sd42);
		pending_values.push_back(-35'sd42);
		wait_drained();

		// only bit 0 of the sign register counts, and index 3 is ignored
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data <= CFG_W'($urandom());
		set_format(4'd3, 4'd2, 4'hE);
		pending_values.push_back(35'sd1);
		pending_values.push_back(-35'sd100);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin int_d = 4'd1;  frac_d = 4'd0;  sign_data = 4'd0; end
				1: begin int_d = 4'd10; frac_d = 4'd0;  sign_data = 4'd1; end
				2: begin int_d = 4'd1;  frac_d = 4'd9;  sign_data = 4'd1; end
				3: begin int_d = 4'd0;  frac_d = 4'd0;  sign_data = 4'd0; end
				4: begin int_d = 4'd15; frac_d = 4'd15; sign_data = 4'hF; end
				5: begin int_d = 4'd5;  frac_d = 4'd5;  sign_data = 4'd0; end
				default: begin
					int_d = CFG_W'($urandom_range(0, 15));
					frac_d = CFG_W'($urandom_range(0, 15));
					sign_data = CFG_W'($urandom_range(0, 15));
				end
			endcase
			set_format(int_d, frac_d, sign_data);
			@(posedge clk);
			no_idle <= (p == 3);
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_values.push_back(random_value());
			// receiver holds off while values keep coming
			if (p == 5)
				long_stall_req <= ~long_stall_req;
			wait_drained();
		end

		@(posedge clk);
		no_idle <= 1'b0;
		wait_drained();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fpdf_pkg.sv
rtl/fpdf_bcd_cell.sv
rtl/fpdf_conv.sv
rtl/fpdf_emit.sv
rtl/fixed_point_decimal_text_formatter_top.sv
sim/tb_fixed_point_decimal_text_formatter_top.sv
